@@ hdl/ppcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_pkg
// Shared types and constants of the PWM prescale and compare calculator.
// ----------------------------------------------------------------------------
package ppcc_pkg;

    localparam int MAX_PRESCALE = 7;
    localparam int COUNT_BITS   = 16;
    localparam int DIV_BITS     = 32;
    localparam int PRES_BITS    = 3;
    localparam int NUM_PRES     = MAX_PRESCALE + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FREQ_LOW = 2'd1;
    localparam logic [1:0] ST_TOL      = 2'd2;
    localparam logic [1:0] ST_DUTY     = 2'd3;

    localparam logic [1:0] REG_CLOCK_HZ  = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;

    localparam logic [31:0] CLOCK_RESET = 32'd150000000;
    localparam logic [16:0] TOL_RESET   = 17'd655;

    localparam logic [13:0] DUTY_FULL = 14'd10000;
    localparam logic [13:0] DUTY_HALF = 14'd5000;
    localparam logic [30:0] DUTY_RECIP = 31'd1759218604;
    localparam int          RECIP_SHIFT = 44;

    typedef struct packed {
        logic                valid;
        logic [DIV_BITS-1:0] freq;
        logic [13:0]         duty;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] rem;
    } t_div;

endpackage
`default_nettype wire

@@ hdl/ppcc_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_div_cell
// One restoring division cell: develops one quotient bit per word.
// ----------------------------------------------------------------------------
module ppcc_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire ppcc_pkg::t_div i_word,
    output      ppcc_pkg::t_div o_word
);
    import ppcc_pkg::*;

    t_div                r_word;
    t_div                n_word;
    logic [DIV_BITS:0]   w_trial;
    logic                w_ge;
    logic [DIV_BITS:0]   w_diff;

    always_comb begin
        w_trial = {i_word.rem, i_word.num[DIV_BITS-1]};
        w_ge    = w_trial >= {1'b0, i_word.freq};
        w_diff  = w_trial - {1'b0, i_word.freq};
        n_word       = i_word;
        n_word.num   = {i_word.num[DIV_BITS-2:0], 1'b0};
        n_word.quo   = {i_word.quo[DIV_BITS-2:0], w_ge};
        n_word.rem   = w_ge ? w_diff[DIV_BITS-1:0] : w_trial[DIV_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word.valid <= n_word.valid;
        end
        if (i_en) begin
            r_word.freq <= n_word.freq;
            r_word.duty <= n_word.duty;
            r_word.num  <= n_word.num;
            r_word.quo  <= n_word.quo;
            r_word.rem  <= n_word.rem;
        end
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

@@ hdl/ppcc_select.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppcc_select
// Prescale search on the full quotient, then rounded high and low counts.
// ----------------------------------------------------------------------------
module ppcc_select (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire ppcc_pkg::t_div  i_word,
    input  wire logic [31:0]     i_clock_hz,
    input  wire logic [16:0]     i_tolerance,
    output      logic            o_valid,
    output      logic [1:0]      o_status,
    output      logic [2:0]      o_prescale,
    output      logic [15:0]     o_period_count,
    output      logic [15:0]     o_high_count,
    output      logic [15:0]     o_low_count
);
    import ppcc_pkg::*;

    // Stage one: remainders and range flags for every prescale.
    logic               r1_valid;
    logic               r1_fz;
    logic [13:0]        r1_duty;
    logic [31:0]        r1_quo;
    logic [39:0]        r1_rem [NUM_PRES];
    logic [NUM_PRES-1:0] r1_big;
    logic [48:0]        r1_tolc;
    logic [39:0]        n1_rem [NUM_PRES];
    logic [NUM_PRES-1:0] n1_big;
    logic [6:0]         w_mask;

    always_comb begin
        for (int p = 0; p < NUM_PRES; p++) begin
            w_mask    = 7'((8'd1 << p) - 8'd1);
            n1_rem[p] = 40'(w_mask & i_word.quo[6:0]) * 40'(i_word.freq)
                        + 40'(i_word.rem);
            n1_big[p] = (i_word.quo >> p) >= 32'(1 << COUNT_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_word.valid;
        end
        if (i_en) begin
            r1_fz   <= i_word.freq == '0;
            r1_duty <= i_word.duty;
            r1_quo  <= i_word.quo;
            r1_rem  <= n1_rem;
            r1_big  <= n1_big;
            r1_tolc <= 49'(i_tolerance) * 49'(i_clock_hz);
        end
    end

    // Stage two: search from the largest prescale down.
    logic        r2_valid;
    logic [1:0]  r2_status;
    logic [2:0]  r2_pres;
    logic [15:0] r2_period;
    logic [13:0] r2_duty;
    logic [1:0]  n2_status;
    logic [2:0]  n2_pres;
    logic        w_hit;
    logic        w_ok;

    always_comb begin
        n2_pres = '0;
        w_hit   = 1'b0;
        w_ok    = 1'b0;
        for (int p = 0; p < NUM_PRES; p++) begin
            if (r1_big[p] || ({r1_rem[p], 16'd0} <= {7'd0, r1_tolc})) begin
                n2_pres = 3'(p);
                w_hit   = 1'b1;
                w_ok    = !r1_big[p];
            end
        end
        priority if (r1_fz) begin
            n2_status = ST_FREQ_LOW;
        end else if (!w_hit) begin
            n2_status = ST_TOL;
        end else if (!w_ok) begin
            n2_status = ST_FREQ_LOW;
        end else if (r1_duty > DUTY_FULL) begin
            n2_status = ST_DUTY;
        end else begin
            n2_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_status <= n2_status;
            r2_pres   <= (n2_status == ST_OK || n2_status == ST_DUTY) ? n2_pres : '0;
            r2_period <= (n2_status == ST_OK) ? 16'(r1_quo >> n2_pres) : '0;
            r2_duty   <= r1_duty;
        end
    end

    // Stage three: scaled duty with half a unit added.
    logic        r3_valid;
    logic [1:0]  r3_status;
    logic [2:0]  r3_pres;
    logic [15:0] r3_period;
    logic [29:0] r3_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_status <= r2_status;
            r3_pres   <= r2_pres;
            r3_period <= r2_period;
            r3_x      <= 30'(r2_period) * 30'(r2_duty) + 30'(DUTY_HALF);
        end
    end

    // Stage four: estimate of the quotient by the reciprocal.
    logic        r4_valid;
    logic [1:0]  r4_status;
    logic [2:0]  r4_pres;
    logic [15:0] r4_period;
    logic [29:0] r4_x;
    logic [16:0] r4_est;
    logic [60:0] w_prod;

    assign w_prod = 61'(r3_x) * 61'(DUTY_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_status <= r3_status;
            r4_pres   <= r3_pres;
            r4_period <= r3_period;
            r4_x      <= r3_x;
            r4_est    <= 17'(w_prod >> RECIP_SHIFT);
        end
    end

    // Stage five: remainder of the estimate.
    logic        r5_valid;
    logic [1:0]  r5_status;
    logic [2:0]  r5_pres;
    logic [15:0] r5_period;
    logic [16:0] r5_est;
    logic [29:0] r5_rm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
        if (i_en) begin
            r5_status <= r4_status;
            r5_pres   <= r4_pres;
            r5_period <= r4_period;
            r5_est    <= r4_est;
            r5_rm     <= r4_x - 30'(r4_est) * 30'(DUTY_FULL);
        end
    end

    // Stage six: correction and output register.
    logic        r6_valid;
    logic [1:0]  r6_status;
    logic [2:0]  r6_pres;
    logic [15:0] r6_period;
    logic [15:0] r6_high;
    logic [15:0] r6_low;
    logic [16:0] n6_high;

    assign n6_high = r5_est + 17'(r5_rm >= 30'(DUTY_FULL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
        if (i_en) begin
            r6_status <= r5_status;
            r6_pres   <= r5_pres;
            r6_period <= r5_period;
            r6_high   <= (r5_status == ST_OK) ? n6_high[15:0] : '0;
            r6_low    <= (r5_status == ST_OK) ? r5_period - n6_high[15:0] : '0;
        end
    end

    assign o_valid        = r6_valid;
    assign o_status       = r6_status;
    assign o_prescale     = r6_pres;
    assign o_period_count = r6_period;
    assign o_high_count   = r6_high;
    assign o_low_count    = r6_low;

endmodule
`default_nettype wire

@@ hdl/pwm_prescale_and_compare_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_prescale_and_compare_calc
// Picks a timer prescale for a PWM frequency and derives period, high and
// low compare counts.
// The path from input word to output word runs through one input register,
// 32 division cells and six search and rounding stages.
// Throughput is one word per cycle; the whole pipeline holds while a
// finished word is stalled at the output.
// Synchronous active-low reset clears all valid flags and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pwm_prescale_and_compare_calc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [31:0] i_freq_hz,
    input  wire logic [13:0] i_duty,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [1:0]  o_status,
    output      logic [2:0]  o_prescale,
    output      logic [15:0] o_period_count,
    output      logic [15:0] o_high_count,
    output      logic [15:0] o_low_count
);
    import ppcc_pkg::*;

    logic [31:0] r_clock_hz;
    logic [16:0] r_tolerance;
    logic        w_en;
    t_div        r_in;
    t_div        w_chain [DIV_BITS+1];

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz  <= CLOCK_RESET;
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CLOCK_HZ:  r_clock_hz  <= i_cfg_data;
                REG_TOLERANCE: r_tolerance <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= i_in_valid;
        end
        if (w_en) begin
            r_in.freq <= i_freq_hz;
            r_in.duty <= i_duty;
            r_in.num  <= r_clock_hz;
            r_in.quo  <= '0;
            r_in.rem  <= '0;
        end
    end

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_cell
        ppcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    ppcc_select u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_word         (w_chain[DIV_BITS]),
        .i_clock_hz     (r_clock_hz),
        .i_tolerance    (r_tolerance),
        .o_valid        (o_out_valid),
        .o_status       (o_status),
        .o_prescale     (o_prescale),
        .o_period_count (o_period_count),
        .o_high_count   (o_high_count),
        .o_low_count    (o_low_count)
    );

endmodule
`default_nettype wire
